FILE: sv/ecfe_pkg.sv
// Shared types, codes and constants of the echo/checksum frame engine.
`default_nettype none
package ecfe_pkg;

	localparam int unsigned FRAME_BYTES_DEF = 15;
	localparam int unsigned IDX_W           = 6;

	localparam logic       FUNC_SEND  = 1'b0;
	localparam logic       FUNC_REPLY = 1'b1;
	localparam logic       KIND_BYTE    = 1'b0;
	localparam logic       KIND_VERDICT = 1'b1;

	localparam logic [2:0] VERDICT_OK       = 3'd0;
	localparam logic [2:0] VERDICT_BAD_SUM  = 3'd1;
	localparam logic [2:0] VERDICT_BAD_ECHO = 3'd2;
	localparam logic [2:0] VERDICT_REFUSED  = 3'd3;
	localparam logic [2:0] VERDICT_BAD_KEY  = 3'd4;

	localparam logic [7:0] KEY_COMMAND   = 8'h00;
	localparam logic [7:0] KEY_PROGRAM   = 8'h01;
	localparam logic [7:0] KEY_REQUEST   = 8'h02;
	localparam logic [7:0] KEY_TELEMETRY = 8'h03;
	localparam logic [7:0] REPORT_BYTE   = 8'h52;
	localparam logic [7:0] FILL_BYTE     = 8'h4E;
	localparam logic [7:0] ECHO_MAX      = 8'hFE;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] out_byte;
		logic       frame_last;
		logic [2:0] verdict;
	} rsp_t;

	// Up to three results caused by one request item.
	typedef struct packed {
		logic [1:0] cnt;
		rsp_t       first;
		logic [7:0] sum_hi;
		logic [7:0] sum_lo;
	} bundle_t;

	// Byte expected at a given position of an accepted-report reply.
	function automatic logic [7:0] expected_report(input logic [IDX_W-1:0] pos);
		logic [7:0] v;
		if (pos == '0)
			v = REPORT_BYTE;
		else if (pos < IDX_W'(4))
			v = 8'h00;
		else
			v = FILL_BYTE;
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: sv/echo_checksum_frame_engine.sv
// Top level of the echo/checksum frame engine: input register, core and result buffer.
// An accepted item waits in the input register, then the result buffer offers its results.
// Throughput: one item per cycle while results are taken; the last payload byte of a
// frame occupies the result port for its three results (byte, checksum high, checksum low).
// Reset: arst_n clears all framing and reply state and empties both register stages.
`default_nettype none
module echo_checksum_frame_engine #(
	parameter int unsigned FRAME_BYTES = ecfe_pkg::FRAME_BYTES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire ecfe_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output ecfe_pkg::rsp_t      rsp
);
	import ecfe_pkg::*;

	// The input register decouples the request side from the result buffer, so a
	// new transfer enters an empty input register even while a finished result waits.
	logic    valid_s1;
	req_t    item_s1;
	logic    advance;
	logic    can_load;
	bundle_t bundle;

	// The held item moves into the core and the result buffer in the same cycle;
	// all framing state is updated at that moment, keeping items in order.
	assign advance   = valid_s1 && can_load;
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid)
			item_s1 <= req;
	end

	// The core keeps the echo counter, running sums and indexes, and works out
	// every result of the held item with short logic.
	ecfe_core #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.bundle (bundle)
	);

	// The result buffer takes up to three results at once and presents them one
	// transfer at a time; it accepts a new set when its last result leaves.
	ecfe_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.bundle    (bundle),
		.can_load  (can_load),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

FILE: sv/ecfe_core.sv
// Framing and reply checking state with the result computation for one item.
`default_nettype none
module ecfe_core #(
	parameter int unsigned FRAME_BYTES = ecfe_pkg::FRAME_BYTES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire ecfe_pkg::req_t  item,
	output ecfe_pkg::bundle_t    bundle
);
	import ecfe_pkg::*;

	localparam logic [IDX_W-1:0] PAYLOAD_LAST = IDX_W'(FRAME_BYTES - 3);
	localparam logic [IDX_W-1:0] CHECK_POS    = IDX_W'(FRAME_BYTES - 2);
	localparam logic [IDX_W-1:0] REPLY_END    = IDX_W'(FRAME_BYTES - 1);

	logic [7:0]       echo_q;
	logic [IDX_W-1:0] send_index_q;
	logic [15:0]      send_sum_q;
	logic [7:0]       sent_key_q;
	logic [7:0]       sent_echo_q;
	logic [IDX_W-1:0] reply_index_q;
	logic [15:0]      reply_sum_q;
	logic [7:0]       check_high_q;
	logic [7:0]       reply_key_q;
	logic [7:0]       reply_echo_q;
	logic             mismatch_q;

	logic [IDX_W-1:0] sidx;
	logic [IDX_W-1:0] ridx;
	logic [7:0]       send_byte;
	logic [15:0]      send_sum_n;
	logic [2:0]       verdict;
	logic             key_is_cmd;

	assign sidx       = (send_index_q > PAYLOAD_LAST) ? PAYLOAD_LAST : send_index_q;
	assign ridx       = (reply_index_q > REPLY_END) ? REPLY_END : reply_index_q;
	assign send_byte  = (sidx == IDX_W'(1)) ? echo_q : item.data_byte;
	assign send_sum_n = send_sum_q + {8'h00, send_byte};
	assign key_is_cmd = (sent_key_q == KEY_COMMAND) || (sent_key_q == KEY_PROGRAM);

	always_comb begin
		if ({check_high_q, item.data_byte} != reply_sum_q)
			verdict = VERDICT_BAD_SUM;
		else if (reply_echo_q != sent_echo_q)
			verdict = VERDICT_BAD_ECHO;
		else if (key_is_cmd && mismatch_q)
			verdict = VERDICT_REFUSED;
		else if (sent_key_q == KEY_REQUEST && reply_key_q != KEY_TELEMETRY)
			verdict = VERDICT_BAD_KEY;
		else
			verdict = VERDICT_OK;
	end

	always_comb begin
		bundle.sum_hi = send_sum_n[15:8];
		bundle.sum_lo = send_sum_n[7:0];
		if (item.func == FUNC_SEND) begin
			bundle.first = '{kind: KIND_BYTE, out_byte: send_byte, frame_last: 1'b0,
				verdict: VERDICT_OK};
			bundle.cnt   = (sidx == PAYLOAD_LAST) ? 2'd3 : 2'd1;
		end else begin
			bundle.first = '{kind: KIND_VERDICT, out_byte: 8'h00, frame_last: 1'b1,
				verdict: verdict};
			bundle.cnt   = (ridx == REPLY_END) ? 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_q        <= '0;
			send_index_q  <= '0;
			send_sum_q    <= '0;
			sent_key_q    <= '0;
			sent_echo_q   <= '0;
			reply_index_q <= '0;
			reply_sum_q   <= '0;
			check_high_q  <= '0;
			reply_key_q   <= '0;
			reply_echo_q  <= '0;
			mismatch_q    <= 1'b0;
		end else if (fire) begin
			if (item.func == FUNC_SEND) begin
				if (sidx == '0)
					sent_key_q <= item.data_byte;
				if (sidx == IDX_W'(1)) begin
					sent_echo_q <= echo_q;
					echo_q      <= (echo_q >= ECHO_MAX) ? 8'h00 : echo_q + 8'd1;
				end
				if (sidx == PAYLOAD_LAST) begin
					send_index_q <= '0;
					send_sum_q   <= '0;
				end else begin
					send_index_q <= sidx + IDX_W'(1);
					send_sum_q   <= send_sum_n;
				end
			end else begin
				if (ridx < CHECK_POS) begin
					reply_sum_q   <= reply_sum_q + {8'h00, item.data_byte};
					reply_index_q <= ridx + IDX_W'(1);
					if (ridx == '0)
						reply_key_q <= item.data_byte;
					if (ridx == IDX_W'(1))
						reply_echo_q <= item.data_byte;
					else if (item.data_byte != expected_report(ridx))
						mismatch_q <= 1'b1;
				end else if (ridx == CHECK_POS) begin
					check_high_q  <= item.data_byte;
					reply_index_q <= ridx + IDX_W'(1);
				end else begin
					reply_index_q <= '0;
					reply_sum_q   <= '0;
					mismatch_q    <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/ecfe_outq.sv
// Result buffer that holds the results of one item and hands them out in order.
`default_nettype none
module ecfe_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire ecfe_pkg::bundle_t bundle,
	output logic                   can_load,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output ecfe_pkg::rsp_t         rsp
);
	import ecfe_pkg::*;

	logic [1:0] cnt_q;
	rsp_t       slot0_q;
	rsp_t       slot1_q;
	rsp_t       slot2_q;
	logic       pop;

	assign rsp_valid = (cnt_q != 2'd0);
	assign rsp       = slot0_q;
	assign pop       = rsp_valid && rsp_ready;
	assign can_load  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= bundle.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= bundle.first;
			slot1_q <= '{kind: KIND_BYTE, out_byte: bundle.sum_hi, frame_last: 1'b0,
				verdict: VERDICT_OK};
			slot2_q <= '{kind: KIND_BYTE, out_byte: bundle.sum_lo, frame_last: 1'b1,
				verdict: VERDICT_OK};
		end else if (pop) begin
			slot0_q <= slot1_q;
			slot1_q <= slot2_q;
		end
	end

endmodule
`default_nettype wire

FILE: sv/ecfe_checker.sv
// Port-level checker of the echo/checksum frame engine and its bind statement.
`default_nettype none
module ecfe_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_ready,
	input wire ecfe_pkg::req_t req,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input wire ecfe_pkg::rsp_t rsp
);
	import ecfe_pkg::*;

	// A stalled result stays offered and unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed or dropped while stalled");

	// A verdict closes the reply and carries no byte.
	a_verdict_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_VERDICT |-> rsp.frame_last && rsp.out_byte == 8'h00)
		else $error("verdict without frame_last or with a byte");

	// Framed bytes carry no verdict code.
	a_byte_no_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_BYTE |-> rsp.verdict == VERDICT_OK)
		else $error("framed byte with a verdict code");

	// A stalled request stays offered and unchanged until its transfer.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request changed or dropped while stalled");

endmodule

bind echo_checksum_frame_engine ecfe_checker u_ecfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the echo/checksum frame engine: stimulus, prediction and checks.
`timescale 1ns / 1ps
module tb_top;
	import ecfe_pkg::*;

	// The block runs with its default frame length. A request frame is
	// FRAME_LEN - 2 bytes long on the input side, and a reply frame is
	// FRAME_LEN bytes long, the last two being its checksum.
	localparam int FRAME_LEN      = FRAME_BYTES_DEF;
	localparam int PAYLOAD_LAST   = FRAME_LEN - 3;
	localparam int CHECK_HIGH_POS = FRAME_LEN - 2;

	// Amount of random traffic after the directed frames.
	localparam int RANDOM_ITEMS = 140;
	// In the last part of the run neither side starts a new idle burst.
	localparam int CALM_ITEMS   = 60;
	// Cycles allowed after the last expected result for stray outputs.
	localparam int DRAIN_CYCLES = 8;

	typedef enum int {
		RS_REPORT,
		RS_TELEMETRY,
		RS_BAD_SUM,
		RS_BAD_ECHO,
		RS_BAD_PATTERN,
		RS_BAD_KEY,
		RS_JUNK
	} reply_style_e;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_ready;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	rsp_t  rsp;

	echo_checksum_frame_engine #(
		.FRAME_BYTES(FRAME_LEN)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// Pending input items, filled once at time zero and drained by the driver.
	req_t        stim_q[$];
	// Predicted engine outputs, oldest first.
	rsp_t        engine_results_q[$];

	int unsigned item_total     = 0;
	int unsigned accepted_count = 0;
	int unsigned result_count   = 0;
	int unsigned frames_closed  = 0;
	int unsigned fail_count     = 0;
	int unsigned cycle_count    = 0;
	int unsigned cycle_limit    = 32'd4_000_000;
	int unsigned verdict_hits[5];
	logic        req_taken      = 1'b0;
	int unsigned send_gap       = 0;
	int unsigned rsp_gap        = 0;

	// Predictor state. It mirrors the framing and reply tracking of the block.
	logic [7:0]  m_echo;
	int unsigned m_send_idx;
	logic [15:0] m_send_sum;
	logic [7:0]  m_sent_key;
	logic [7:0]  m_sent_echo;
	int unsigned m_reply_idx;
	logic [15:0] m_reply_sum;
	logic [7:0]  m_check_high;
	logic [7:0]  m_reply_key;
	logic [7:0]  m_reply_echo;
	logic        m_mismatch;

	// Stimulus generator bookkeeping. The generator only follows frame
	// positions and the echo number, so that well-formed replies can carry
	// the echo of the latest request frame.
	int unsigned gen_send_idx  = 0;
	int unsigned gen_reply_idx = 0;
	logic [7:0]  gen_echo      = 8'h00;
	logic [7:0]  gen_last_echo = 8'h00;
	int unsigned gen_wraps     = 0;
	logic [7:0]  send_bytes[$];
	logic [7:0]  reply_bytes[$];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic rsp_t make_result(input logic k, input logic [7:0] b,
	                                     input logic last, input logic [2:0] v);
		rsp_t r;
		r.kind       = k;
		r.out_byte   = b;
		r.frame_last = last;
		r.verdict    = v;
		return r;
	endfunction

	// Advance the predicted engine by one accepted transfer and queue the
	// results it causes: one byte for most request bytes, three for the last
	// payload byte, nothing for reply bytes but the final one, which yields
	// a verdict.
	task automatic engine_step(input req_t item);
		int unsigned idx;
		logic [7:0]  b;
		logic [7:0]  want_b;
		logic [2:0]  v;
		b = item.data_byte;
		if (item.func == FUNC_SEND) begin
			idx = (m_send_idx > PAYLOAD_LAST) ? PAYLOAD_LAST : m_send_idx;
			if (idx == 0)
				m_sent_key = b;
			if (idx == 1) begin
				// The echo number replaces whatever came in at byte 1.
				b           = m_echo;
				m_sent_echo = m_echo;
				m_echo      = (m_echo >= ECHO_MAX) ? 8'h00 : m_echo + 8'd1;
			end
			m_send_sum = m_send_sum + {8'h00, b};
			engine_results_q.push_back(make_result(KIND_BYTE, b, 1'b0, VERDICT_OK));
			if (idx == PAYLOAD_LAST) begin
				engine_results_q.push_back(make_result(KIND_BYTE, m_send_sum[15:8], 1'b0,
				                                       VERDICT_OK));
				engine_results_q.push_back(make_result(KIND_BYTE, m_send_sum[7:0], 1'b1,
				                                       VERDICT_OK));
				m_send_idx = 0;
				m_send_sum = '0;
			end else begin
				m_send_idx = idx + 1;
			end
		end else begin
			idx = (m_reply_idx > CHECK_HIGH_POS + 1) ? CHECK_HIGH_POS + 1 : m_reply_idx;
			if (idx < CHECK_HIGH_POS) begin
				m_reply_sum = m_reply_sum + {8'h00, b};
				if (idx == 0)
					m_reply_key = b;
				// Byte 1 carries the echo and is exempt from the report pattern.
				want_b = (idx == 0) ? REPORT_BYTE : ((idx < 4) ? 8'h00 : FILL_BYTE);
				if (idx == 1)
					m_reply_echo = b;
				else if (b != want_b)
					m_mismatch = 1'b1;
				m_reply_idx = idx + 1;
			end else if (idx == CHECK_HIGH_POS) begin
				m_check_high = b;
				m_reply_idx  = idx + 1;
			end else begin
				// Checks are ranked: checksum, echo, pattern, telemetry key.
				if ({m_check_high, b} != m_reply_sum)
					v = VERDICT_BAD_SUM;
				else if (m_reply_echo != m_sent_echo)
					v = VERDICT_BAD_ECHO;
				else if ((m_sent_key == KEY_COMMAND || m_sent_key == KEY_PROGRAM)
				         && m_mismatch)
					v = VERDICT_REFUSED;
				else if (m_sent_key == KEY_REQUEST && m_reply_key != KEY_TELEMETRY)
					v = VERDICT_BAD_KEY;
				else
					v = VERDICT_OK;
				engine_results_q.push_back(make_result(KIND_VERDICT, 8'h00, 1'b1, v));
				m_reply_idx = 0;
				m_reply_sum = '0;
				m_mismatch  = 1'b0;
			end
		end
	endtask

	// Queue one input item and keep the generator's frame positions in step.
	task automatic push_item(input logic f, input logic [7:0] b);
		req_t it;
		it.func      = f;
		it.data_byte = b;
		if (f == FUNC_SEND) begin
			if (gen_send_idx == 1) begin
				gen_last_echo = gen_echo;
				if (gen_echo >= ECHO_MAX) begin
					gen_echo = 8'h00;
					gen_wraps++;
				end else begin
					gen_echo = gen_echo + 8'd1;
				end
			end
			gen_send_idx = (gen_send_idx == PAYLOAD_LAST) ? 0 : gen_send_idx + 1;
		end else begin
			gen_reply_idx = (gen_reply_idx == FRAME_LEN - 1) ? 0 : gen_reply_idx + 1;
		end
		stim_q.push_back(it);
	endtask

	// Finish any frame that noise left open, with random bytes, so that the
	// next well-formed frame starts at position zero on both sides.
	task automatic align_frames();
		while (gen_send_idx != 0)
			push_item(FUNC_SEND, 8'($urandom_range(0, 255)));
		while (gen_reply_idx != 0)
			push_item(FUNC_REPLY, 8'($urandom_range(0, 255)));
	endtask

	task automatic build_send(input logic [7:0] key);
		send_bytes = {};
		send_bytes.push_back(key);
		for (int p = 1; p <= PAYLOAD_LAST; p++)
			send_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// Build a whole reply frame in the given style, checksum included.
	task automatic build_reply(input reply_style_e style, input logic [7:0] echo);
		logic [7:0]  b;
		logic [15:0] sum;
		int unsigned pos;
		reply_bytes = {};
		for (int p = 0; p < CHECK_HIGH_POS; p++) begin
			case (style)
				RS_TELEMETRY: begin
					b = (p == 0) ? KEY_TELEMETRY : 8'($urandom_range(0, 255));
				end
				RS_BAD_KEY: begin
					b = 8'($urandom_range(0, 255));
					if (p == 0 && b == KEY_TELEMETRY)
						b = b ^ 8'h01;
				end
				RS_JUNK: begin
					b = 8'($urandom_range(0, 255));
				end
				default: begin
					b = (p == 0) ? REPORT_BYTE : ((p < 4) ? 8'h00 : FILL_BYTE);
				end
			endcase
			if (p == 1 && style != RS_JUNK)
				b = echo;
			reply_bytes.push_back(b);
		end
		if (style == RS_BAD_ECHO)
			reply_bytes[1] = reply_bytes[1] ^ 8'($urandom_range(1, 255));
		if (style == RS_BAD_PATTERN) begin
			// Break one compared position; byte 1 is never compared.
			pos = $urandom_range(0, CHECK_HIGH_POS - 2);
			if (pos >= 1)
				pos++;
			reply_bytes[pos] = reply_bytes[pos] ^ 8'($urandom_range(1, 255));
		end
		sum = '0;
		foreach (reply_bytes[i])
			sum = sum + {8'h00, reply_bytes[i]};
		if (style == RS_BAD_SUM)
			sum = sum ^ 16'($urandom_range(1, 65535));
		reply_bytes.push_back(sum[15:8]);
		reply_bytes.push_back(sum[7:0]);
	endtask

	task automatic emit_send();
		foreach (send_bytes[i])
			push_item(FUNC_SEND, send_bytes[i]);
	endtask

	task automatic emit_reply();
		foreach (reply_bytes[i])
			push_item(FUNC_REPLY, reply_bytes[i]);
	endtask

	function automatic logic [7:0] pick_key();
		logic [7:0] k;
		case ($urandom_range(0, 4))
			0:       k = KEY_COMMAND;
			1:       k = KEY_PROGRAM;
			2:       k = KEY_REQUEST;
			3:       k = KEY_TELEMETRY;
			default: k = 8'($urandom_range(0, 255));
		endcase
		return k;
	endfunction

	function automatic reply_style_e pick_style();
		return reply_style_e'($urandom_range(0, 6));
	endfunction

	// A request frame and a reply frame whose bytes are mixed at random. The
	// verdict then sees whichever key and echo have been framed by the time
	// the reply closes.
	task automatic push_interleaved();
		align_frames();
		build_send(pick_key());
		build_reply(pick_style(), gen_echo);
		while (send_bytes.size() != 0 || reply_bytes.size() != 0) begin
			if (reply_bytes.size() == 0
			    || (send_bytes.size() != 0 && $urandom_range(0, 1) == 0))
				push_item(FUNC_SEND, send_bytes.pop_front());
			else
				push_item(FUNC_REPLY, reply_bytes.pop_front());
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
	                           input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic fill_stimulus();
		int unsigned start_size;
		int unsigned n;
		// Directed opening: a command frame whose payload swings between
		// all-zero and all-one bytes, answered by a clean accepted report.
		send_bytes = {};
		send_bytes.push_back(KEY_COMMAND);
		send_bytes.push_back(8'hFF);
		for (int p = 2; p <= PAYLOAD_LAST; p++)
			send_bytes.push_back((p % 2 == 0) ? 8'hFF : 8'h00);
		emit_send();
		build_reply(RS_REPORT, gen_last_echo);
		emit_reply();

		// Random mix: full exchanges with random content, plus lone request
		// frames, lone replies, interleaved frames and raw noise.
		start_size = stim_q.size();
		while (stim_q.size() - start_size < RANDOM_ITEMS) begin
			n = $urandom_range(0, 99);
			if (n < 35) begin
				align_frames();
				build_send(pick_key());
				emit_send();
				build_reply(pick_style(), gen_last_echo);
				emit_reply();
			end else if (n < 50) begin
				align_frames();
				build_reply(pick_style(), gen_last_echo);
				emit_reply();
			end else if (n < 62) begin
				align_frames();
				build_send(pick_key());
				emit_send();
			end else if (n < 75) begin
				push_interleaved();
			end else begin
				repeat ($urandom_range(1, 6))
					push_item($urandom_range(0, 1) ? FUNC_REPLY : FUNC_SEND,
					          8'($urandom_range(0, 255)));
			end
		end
		align_frames();
	endtask

	// Driver: inputs change on the falling edge. A presented item stays put
	// until its transfer; only then may the driver idle or present the next.
	always @(negedge clk) begin : drive_proc
		logic next_valid;
		req_t next_req;
		logic next_ready;
		bit   calm;
		next_valid = req_valid;
		next_req   = req;
		next_ready = rsp_ready;
		calm       = (accepted_count + CALM_ITEMS >= item_total);
		if (arst_n) begin
			if (req_valid && req_taken)
				next_valid = 1'b0;
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (stim_q.size() != 0) begin
					if (!calm && $urandom_range(0, 7) == 0) begin
						// This cycle is the first of the idle burst.
						send_gap = $urandom_range(1, 15) - 1;
					end else begin
						next_req   = stim_q.pop_front();
						next_valid = 1'b1;
					end
				end
			end
			// The result side stalls in bursts independent of the input side.
			if (rsp_gap > 0) begin
				rsp_gap--;
				next_ready = 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				rsp_gap    = $urandom_range(1, 15) - 1;
				next_ready = 1'b0;
			end else begin
				next_ready = 1'b1;
			end
		end
		req_valid <= next_valid;
		req       <= next_req;
		rsp_ready <= next_ready;
	end

	// Monitor: on each rising edge, check a result transfer against the
	// oldest prediction, then feed an input transfer to the predictor. A
	// result never appears in the cycle of its own input transfer, so this
	// order is safe.
	always @(posedge clk) begin : watch_proc
		rsp_t want;
		if (arst_n) begin
			req_taken <= req_valid && req_ready;
			if (rsp_valid && rsp_ready) begin
				result_count++;
				if (engine_results_q.size() == 0) begin
					$error("result transfer with no prediction pending: kind %0d byte 0x%0h",
					       rsp.kind, rsp.out_byte);
					fail_count++;
				end else begin
					want = engine_results_q.pop_front();
					check_field("kind", want.kind, rsp.kind);
					check_field("out_byte", want.out_byte, rsp.out_byte);
					check_field("frame_last", want.frame_last, rsp.frame_last);
					check_field("verdict", want.verdict, rsp.verdict);
				end
				if (rsp.kind == KIND_VERDICT && rsp.verdict <= VERDICT_BAD_KEY)
					verdict_hits[rsp.verdict]++;
				if (rsp.kind == KIND_BYTE && rsp.frame_last)
					frames_closed++;
			end
			if (req_valid && req_ready) begin
				engine_step(req);
				accepted_count++;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > cycle_limit) begin
			$display("timeout after %0d cycles, %0d of %0d transfers accepted",
			         cycle_count, accepted_count, item_total);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		foreach (verdict_hits[i])
			verdict_hits[i] = 0;
		m_echo       = 8'h00;
		m_send_idx   = 0;
		m_send_sum   = '0;
		m_sent_key   = 8'h00;
		m_sent_echo  = 8'h00;
		m_reply_idx  = 0;
		m_reply_sum  = '0;
		m_check_high = 8'h00;
		m_reply_key  = 8'h00;
		m_reply_echo = 8'h00;
		m_mismatch   = 1'b0;

		fill_stimulus();
		item_total = stim_q.size();
		// Worst case per item: the longest input gap plus three results, each
		// behind the longest result stall, and the pipeline itself; then margin.
		cycle_limit = item_total * 200 + 10000;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (!(accepted_count == item_total && engine_results_q.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (engine_results_q.size() != 0) begin
			$error("%0d predicted results never arrived", engine_results_q.size());
			fail_count++;
		end

		$display("%0d input transfers, %0d result transfers, %0d request frames closed",
		         accepted_count, result_count, frames_closed);
		$display("echo wrapped %0d time(s)", gen_wraps);
		$display("verdicts: ok %0d, bad checksum %0d, bad echo %0d, refused %0d, bad key %0d",
		         verdict_hits[VERDICT_OK], verdict_hits[VERDICT_BAD_SUM],
		         verdict_hits[VERDICT_BAD_ECHO], verdict_hits[VERDICT_REFUSED],
		         verdict_hits[VERDICT_BAD_KEY]);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: sim.f
sv/ecfe_pkg.sv
sv/ecfe_core.sv
sv/ecfe_outq.sv
sv/echo_checksum_frame_engine.sv
sv/ecfe_checker.sv
verif/tb_top.sv
